[design/afk_pkg.sv]
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types and constants of the arm forward kinematics block: angle
// folding limits, CORDIC seed and arctangent table, matrix and queue types.
// ----------------------------------------------------------------------------
package afk_pkg;

   localparam int MAX_STAGES = 24;
   localparam int JOINTS     = 5;

   localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
   localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
   localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;

   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [32:0] TRIG_ONE  = 33'sd16384;

   // atan(2^-i) in 2^-22 degree
   localparam logic signed [31:0] ATAN_TAB [0:MAX_STAGES-1] = '{
      32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
      32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
      32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
      32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
      32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
      32'sd229,       32'sd115,       32'sd57,       32'sd29
   };

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK1_Z = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK2_Z = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK3_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK4_Z = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK5_X = 3'd4;

   localparam logic [1:0] POS_COLUMN = 2'd3;

   typedef logic signed [15:0] trig_type;
   typedef logic signed [15:0] offset_type;
   typedef logic signed [19:0] entry_type;
   typedef logic signed [35:0] prod_type;
   typedef logic signed [36:0] pos_type;

   typedef struct packed {
      trig_type [JOINTS-1:0] s;
      trig_type [JOINTS-1:0] c;
   } sincos_type;

   typedef struct packed {
      entry_type [2:0][2:0] r;
      pos_type   [2:0]      p;
   } xform_type;

endpackage

[design/afk_front.sv]
// ----------------------------------------------------------------------------
// afk_front
// Takes joint angle words, folds each angle to +-90 degrees and runs five
// pipelined CORDIC lanes; holds a credit count against the queue behind it.
// ----------------------------------------------------------------------------
module afk_front import afk_pkg::*; #(
   parameter int STAGES = 16,
   parameter int QDEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  trig_type [JOINTS-1:0]   angle,
   input  logic                    pop,
   output logic                    busy,
   output logic                    push,
   output sincos_type              push_data
);

   localparam int CW = $clog2(QDEPTH + 1);

   logic signed [16:0] red_m [JOINTS];
   logic signed [16:0] red_w [JOINTS];
   logic signed [16:0] red_f [JOINTS];
   logic               red_neg [JOINTS];

   logic signed [32:0] x_ff [0:STAGES][JOINTS];
   logic signed [32:0] y_ff [0:STAGES][JOINTS];
   logic signed [31:0] z_ff [0:STAGES][JOINTS];
   logic               neg_ff [0:STAGES][JOINTS];
   logic               vld_ff [0:STAGES];

   logic signed [32:0] rnd_x [JOINTS];
   logic signed [32:0] rnd_y [JOINTS];
   trig_type           fin_c [JOINTS];
   trig_type           fin_s [JOINTS];

   sincos_type         push_data_ff, push_data_in;
   logic               push_ff;
   logic [CW-1:0]      credit_ff, credit_in;
   logic               accept;

   assign busy   = (credit_ff == CW'(QDEPTH));
   assign accept = start & ~busy;

   // wrap to [-180,180), then fold into [-90,90]
   always_comb begin
      for (int j = 0; j < JOINTS; j++) begin
         red_m[j] = {angle[j][15], angle[j]};
         if (red_m[j] >= FULL_TURN)
            red_m[j] = red_m[j] - FULL_TURN;
         else if (red_m[j] <= -FULL_TURN)
            red_m[j] = red_m[j] + FULL_TURN;
         red_w[j] = red_m[j];
         if (red_m[j] >= HALF_TURN)
            red_w[j] = red_m[j] - FULL_TURN;
         else if (red_m[j] < -HALF_TURN)
            red_w[j] = red_m[j] + FULL_TURN;
         red_f[j]   = red_w[j];
         red_neg[j] = 1'b0;
         if (red_w[j] > QUARTER_TURN) begin
            red_f[j]   = red_w[j] - HALF_TURN;
            red_neg[j] = 1'b1;
         end else if (red_w[j] < -QUARTER_TURN) begin
            red_f[j]   = red_w[j] + HALF_TURN;
            red_neg[j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < JOINTS; j++) begin
         x_ff[0][j]   <= CORDIC_X0;
         y_ff[0][j]   <= '0;
         z_ff[0][j]   <= {red_f[j][15:0], 16'b0};
         neg_ff[0][j] <= red_neg[j];
      end
      for (int k = 0; k < STAGES; k++) begin
         for (int j = 0; j < JOINTS; j++) begin
            neg_ff[k+1][j] <= neg_ff[k][j];
            if (z_ff[k][j] >= 0) begin
               x_ff[k+1][j] <= x_ff[k][j] - (y_ff[k][j] >>> k);
               y_ff[k+1][j] <= y_ff[k][j] + (x_ff[k][j] >>> k);
               z_ff[k+1][j] <= z_ff[k][j] - ATAN_TAB[k];
            end else begin
               x_ff[k+1][j] <= x_ff[k][j] + (y_ff[k][j] >>> k);
               y_ff[k+1][j] <= y_ff[k][j] - (x_ff[k][j] >>> k);
               z_ff[k+1][j] <= z_ff[k][j] + ATAN_TAB[k];
            end
         end
      end
   end

   // round to Q1.14, clamp to +-1.0, undo the fold
   always_comb begin
      for (int j = 0; j < JOINTS; j++) begin
         rnd_x[j] = (x_ff[STAGES][j] + 33'sd32768) >>> 16;
         rnd_y[j] = (y_ff[STAGES][j] + 33'sd32768) >>> 16;
         if (rnd_x[j] > TRIG_ONE)       rnd_x[j] = TRIG_ONE;
         else if (rnd_x[j] < -TRIG_ONE) rnd_x[j] = -TRIG_ONE;
         if (rnd_y[j] > TRIG_ONE)       rnd_y[j] = TRIG_ONE;
         else if (rnd_y[j] < -TRIG_ONE) rnd_y[j] = -TRIG_ONE;
         if (neg_ff[STAGES][j]) begin
            rnd_x[j] = -rnd_x[j];
            rnd_y[j] = -rnd_y[j];
         end
         fin_c[j] = rnd_x[j][15:0];
         fin_s[j] = rnd_y[j][15:0];
      end
      for (int j = 0; j < JOINTS; j++) begin
         push_data_in.c[j] = fin_c[j];
         push_data_in.s[j] = fin_s[j];
      end
   end

   always_comb begin
      credit_in = credit_ff;
      if (accept && !pop)
         credit_in = credit_ff + 1'b1;
      else if (!accept && pop)
         credit_in = credit_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      push_data_ff <= push_data_in;
      if (reset) begin
         for (int k = 0; k <= STAGES; k++)
            vld_ff[k] <= 1'b0;
         push_ff   <= 1'b0;
         credit_ff <= '0;
      end else begin
         vld_ff[0] <= accept;
         for (int k = 0; k < STAGES; k++)
            vld_ff[k+1] <= vld_ff[k];
         push_ff   <= vld_ff[STAGES];
         credit_ff <= credit_in;
      end
   end

   assign push      = push_ff;
   assign push_data = push_data_ff;

   a_pop_has_credit: assert property (@(posedge clock) disable iff (reset)
      pop |-> credit_ff != '0)
      else $error("queue pop without an outstanding word");

endmodule

[design/afk_queue.sv]
// ----------------------------------------------------------------------------
// afk_queue
// Short register queue of sine/cosine sets between the front and back ends.
// ----------------------------------------------------------------------------
module afk_queue import afk_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sincos_type push_data,
   input  logic       pop,
   output logic       empty,
   output sincos_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   sincos_type    mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          full;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (!push && pop)
            count_ff <= count_ff - 1'b1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

[design/afk_chain_step.sv]
// ----------------------------------------------------------------------------
// afk_chain_step
// One product of the running transform with a pitch (Y) or roll (X) joint
// transform: multiply cycle, then sum and round cycle.
// ----------------------------------------------------------------------------
module afk_chain_step import afk_pkg::*; #(
   parameter bit ROLL  = 1'b0,
   parameter int JOINT = 1
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  xform_type  in_acc,
   input  sincos_type in_sc,
   input  offset_type offset,
   output logic       out_valid,
   output xform_type  out_acc,
   output sincos_type out_sc
);

   entry_type op_u [3];
   entry_type op_w [3];
   entry_type op_k [3];
   entry_type op_p [3];

   prod_type  m_in [3][4];
   prod_type  m_ff [3][4];
   prod_type  pp_in [3];
   prod_type  pp_ff [3];
   entry_type keep_ff [3];
   pos_type   [2:0] p_ff;
   sincos_type sc_ff, sc2_ff;
   logic      v1_ff, v2_ff;

   logic signed [36:0] sum_a [3];
   logic signed [36:0] sum_b [3];
   logic signed [36:0] rnd_a [3];
   logic signed [36:0] rnd_b [3];
   xform_type acc_in, acc_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (ROLL) begin
            op_u[i] = in_acc.r[i][1];
            op_k[i] = in_acc.r[i][0];
            op_p[i] = in_acc.r[i][0];
         end else begin
            op_u[i] = in_acc.r[i][0];
            op_k[i] = in_acc.r[i][1];
            op_p[i] = in_acc.r[i][2];
         end
         op_w[i] = in_acc.r[i][2];
         m_in[i][0] = $signed(op_u[i]) * $signed(in_sc.c[JOINT]);
         m_in[i][1] = $signed(op_w[i]) * $signed(in_sc.s[JOINT]);
         m_in[i][2] = $signed(op_u[i]) * $signed(in_sc.s[JOINT]);
         m_in[i][3] = $signed(op_w[i]) * $signed(in_sc.c[JOINT]);
         pp_in[i]   = $signed(op_p[i]) * $signed(offset);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         for (int q = 0; q < 4; q++)
            m_ff[i][q] <= m_in[i][q];
         pp_ff[i]   <= pp_in[i];
         keep_ff[i] <= op_k[i];
      end
      p_ff  <= in_acc.p;
      sc_ff <= in_sc;
   end

   always_comb begin
      acc_in = '0;
      for (int i = 0; i < 3; i++) begin
         if (ROLL) begin
            sum_a[i] = 37'(m_ff[i][0]) + 37'(m_ff[i][1]);
            sum_b[i] = 37'(m_ff[i][3]) - 37'(m_ff[i][2]);
         end else begin
            sum_a[i] = 37'(m_ff[i][0]) - 37'(m_ff[i][1]);
            sum_b[i] = 37'(m_ff[i][2]) + 37'(m_ff[i][3]);
         end
         rnd_a[i] = (sum_a[i] + 37'sd8192) >>> 14;
         rnd_b[i] = (sum_b[i] + 37'sd8192) >>> 14;
         if (ROLL) begin
            acc_in.r[i][0] = keep_ff[i];
            acc_in.r[i][1] = rnd_a[i][19:0];
         end else begin
            acc_in.r[i][0] = rnd_a[i][19:0];
            acc_in.r[i][1] = keep_ff[i];
         end
         acc_in.r[i][2] = rnd_b[i][19:0];
         acc_in.p[i]    = p_ff[i] + 37'(pp_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sc2_ff <= sc_ff;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_acc   = acc_ff;
   assign out_sc    = sc2_ff;

endmodule

[design/afk_back.sv]
// ----------------------------------------------------------------------------
// afk_back
// Pops a sine/cosine set when the queue is not empty and the issue gap is out,
// chains the joint transforms in four product steps, sends one pose column a cycle.
// ----------------------------------------------------------------------------
module afk_back import afk_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    empty,
   input  sincos_type              head,
   input  offset_type [JOINTS-1:0] link_offset,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_column_index,
   output logic signed [19:0]      rsp_row0_value,
   output logic signed [19:0]      rsp_row1_value,
   output logic signed [19:0]      rsp_row2_value,
   output logic                    rsp_last_column
);

   localparam logic [1:0] ISSUE_GAP = 2'd3;

   logic [1:0] gap_ff;
   logic       issue;
   xform_type  acc0_in;
   xform_type  acc_w [0:4];
   sincos_type sc_w [0:4];
   logic       vld_w [0:4];
   xform_type  acc0_ff;
   sincos_type sc0_ff;
   logic       v0_ff;

   entry_type  rot_ff [3][3];
   entry_type  pos_ff [3];
   entry_type  pos_in [3];
   logic signed [36:0] pos_rnd [3];
   entry_type  col_val [3];
   logic [1:0] col_ff;
   logic       act_ff;

   logic             rsp_valid_ff;
   logic [1:0]       rsp_column_ff;
   entry_type        rsp_row_ff [3];
   logic             rsp_last_ff;

   assign issue = !empty && (gap_ff == '0);
   assign pop   = issue;

   // base yaw transform straight from the queue head
   always_comb begin
      acc0_in = '0;
      acc0_in.r[0][0] = entry_type'(head.c[0]);
      acc0_in.r[0][1] = -entry_type'(head.s[0]);
      acc0_in.r[1][0] = entry_type'(head.s[0]);
      acc0_in.r[1][1] = entry_type'(head.c[0]);
      acc0_in.r[2][2] = 20'sd16384;
      acc0_in.p[2]    = pos_type'(link_offset[0]) <<< 14;
   end

   always_ff @(posedge clock) begin
      acc0_ff <= acc0_in;
      sc0_ff  <= head;
      if (reset) begin
         gap_ff <= '0;
         v0_ff  <= 1'b0;
      end else begin
         v0_ff <= issue;
         if (issue)
            gap_ff <= ISSUE_GAP;
         else if (gap_ff != '0)
            gap_ff <= gap_ff - 1'b1;
      end
   end

   assign acc_w[0] = acc0_ff;
   assign sc_w[0]  = sc0_ff;
   assign vld_w[0] = v0_ff;

   for (genvar g = 0; g < 4; g++) begin : g_step
      afk_chain_step #(
         .ROLL  (g == 3),
         .JOINT (g + 1)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld_w[g]),
         .in_acc    (acc_w[g]),
         .in_sc     (sc_w[g]),
         .offset    (link_offset[g+1]),
         .out_valid (vld_w[g+1]),
         .out_acc   (acc_w[g+1]),
         .out_sc    (sc_w[g+1])
      );
   end

   // position back to offset units, saturated
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos_rnd[i] = (acc_w[4].p[i] + 37'sd8192) >>> 14;
         if (pos_rnd[i] > 37'sd524287)
            pos_in[i] = 20'sd524287;
         else if (pos_rnd[i] < -37'sd524288)
            pos_in[i] = -20'sd524288;
         else
            pos_in[i] = pos_rnd[i][19:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (col_ff)
            2'd0:    col_val[i] = rot_ff[i][0];
            2'd1:    col_val[i] = rot_ff[i][1];
            2'd2:    col_val[i] = rot_ff[i][2];
            default: col_val[i] = pos_ff[i];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (vld_w[4]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
               rot_ff[i][j] <= acc_w[4].r[i][j];
            pos_ff[i] <= pos_in[i];
         end
      end
      for (int i = 0; i < 3; i++)
         rsp_row_ff[i] <= col_val[i];
      rsp_column_ff <= col_ff;
      rsp_last_ff   <= (col_ff == POS_COLUMN);
      if (reset) begin
         act_ff       <= 1'b0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= act_ff;
         if (vld_w[4]) begin
            act_ff <= 1'b1;
            col_ff <= '0;
         end else if (act_ff) begin
            col_ff <= col_ff + 1'b1;
            if (col_ff == POS_COLUMN)
               act_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_index = rsp_column_ff;
   assign rsp_row0_value   = rsp_row_ff[0];
   assign rsp_row1_value   = rsp_row_ff[1];
   assign rsp_row2_value   = rsp_row_ff[2];
   assign rsp_last_column  = rsp_last_ff & rsp_valid_ff;

   a_columns_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |=>
         rsp_valid_ff && rsp_column_ff == $past(rsp_column_ff) + 2'd1)
      else $error("pose columns broken up or out of order");

endmodule

[design/arm_forward_kinematics.sv]
// ----------------------------------------------------------------------------
// arm_forward_kinematics
// Five-joint forward kinematics: CORDIC front end, short queue, transform
// chain back end emitting the pose as four column words.
// ----------------------------------------------------------------------------
// Path: a taken start passes the CORDIC lanes, push register, queue, yaw
//   register, four product steps and column registers; the four column words
//   follow on consecutive cycles. The back end pops one queue word per pose,
//   the next only once its issue gap runs down; busy rises when the words in
//   the CORDIC lanes and in the queue together reach the queue depth.
// Reset: clears valid bits, queue and credit count, and the link offsets to 0.
// ----------------------------------------------------------------------------
module arm_forward_kinematics import afk_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [15:0]     req_base_yaw_angle,
   input  logic signed [15:0]     req_shoulder_pitch_angle,
   input  logic signed [15:0]     req_elbow_pitch_angle,
   input  logic signed [15:0]     req_wrist_pitch_angle,
   input  logic signed [15:0]     req_wrist_roll_angle,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_column_index,
   output logic signed [19:0]     rsp_row0_value,
   output logic signed [19:0]     rsp_row1_value,
   output logic signed [19:0]     rsp_row2_value,
   output logic                   rsp_last_column,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_write_data
);

   localparam int USED_STAGES = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
   localparam int QDEPTH      = (USED_STAGES + 2) / 4 + 2;

   offset_type [JOINTS-1:0] link_ff;
   trig_type   [JOINTS-1:0] angle;
   logic       push, pop, empty;
   sincos_type push_data, head;

   assign angle = {req_wrist_roll_angle, req_wrist_pitch_angle, req_elbow_pitch_angle,
                   req_shoulder_pitch_angle, req_base_yaw_angle};

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LINK1_Z: link_ff[0] <= csr_write_data;
            CSR_LINK2_Z: link_ff[1] <= csr_write_data;
            CSR_LINK3_Z: link_ff[2] <= csr_write_data;
            CSR_LINK4_Z: link_ff[3] <= csr_write_data;
            CSR_LINK5_X: link_ff[4] <= csr_write_data;
            default: ;
         endcase
      end
   end

   afk_front #(
      .STAGES (USED_STAGES),
      .QDEPTH (QDEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .angle     (angle),
      .pop       (pop),
      .busy      (busy),
      .push      (push),
      .push_data (push_data)
   );

   afk_queue #(
      .DEPTH (QDEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   afk_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .head             (head),
      .link_offset      (link_ff),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_column_index (rsp_column_index),
      .rsp_row0_value   (rsp_row0_value),
      .rsp_row1_value   (rsp_row1_value),
      .rsp_row2_value   (rsp_row2_value),
      .rsp_last_column  (rsp_last_column)
   );

endmodule
